// ----- design/adaptive_mode_follower_filter_core_macros.svh -----
// assertion macros for the adaptive mode follower filter core
// expects clk_i and rst_ni in the scope of use
`ifndef ADAPTIVE_MODE_FOLLOWER_FILTER_CORE_MACROS_SVH
`define ADAPTIVE_MODE_FOLLOWER_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define AMFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AMFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/amff_pkg.sv -----
// shared types, register codes and helpers for the adaptive mode follower filter
// no dependencies
`default_nettype none

package amff_pkg;

  typedef struct packed {
    logic signed [31:0] raw_angle;
    logic        [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] velocity_ff;
    logic        [1:0]  follow_mode;
    logic               accepted;
  } out_t;

  typedef struct packed {
    logic [30:0] dead_band;
    logic [30:0] step_threshold;
    logic [30:0] ramp_threshold;
    logic [15:0] corner_hold_ms;
    logic [30:0] jump_limit;
    logic [63:0] alpha_set;
    logic [47:0] gain_set;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_STILL  = 2'd0,
    MODE_RAMP   = 2'd1,
    MODE_STEP   = 2'd2,
    MODE_CORNER = 2'd3
  } mode_e;

  localparam logic [2:0] REG_DEAD_BAND   = 3'd0;
  localparam logic [2:0] REG_STEP_THR    = 3'd1;
  localparam logic [2:0] REG_RAMP_THR    = 3'd2;
  localparam logic [2:0] REG_CORNER_HOLD = 3'd3;
  localparam logic [2:0] REG_JUMP_LIMIT  = 3'd4;
  localparam logic [2:0] REG_ALPHA_SET   = 3'd5;
  localparam logic [2:0] REG_GAIN_SET    = 3'd6;

  localparam logic [30:0] RST_DEAD_BAND   = 31'd32768;
  localparam logic [30:0] RST_STEP_THR    = 31'd393216;
  localparam logic [30:0] RST_RAMP_THR    = 31'd52429;
  localparam logic [15:0] RST_CORNER_HOLD = 16'd200;
  localparam logic [30:0] RST_JUMP_LIMIT  = 31'd524288;
  localparam logic [63:0] RST_ALPHA_SET   = 64'd5072868695049768141;
  localparam logic [47:0] RST_GAIN_SET    = 48'd63333909856256;

  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;

  localparam logic [9:0]  DT_MAX_MS = 10'd1000;
  localparam logic [16:0] MS_PER_S  = 17'd1000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/amff_regs.sv -----
// apb configuration registers of the adaptive mode follower filter
// depends on amff_pkg
`default_nettype none

module amff_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [amff_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [amff_pkg::PDATA_W-1:0]   pwdata,
  output logic      [amff_pkg::PDATA_W-1:0]   prdata,
  output amff_pkg::cfg_t                      cfg_o
);

  amff_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx   = paddr[amff_pkg::PADDR_W-1:3];
  assign wr_en = psel && penable && pwrite;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_band      <= amff_pkg::RST_DEAD_BAND;
      cfg_q.step_threshold <= amff_pkg::RST_STEP_THR;
      cfg_q.ramp_threshold <= amff_pkg::RST_RAMP_THR;
      cfg_q.corner_hold_ms <= amff_pkg::RST_CORNER_HOLD;
      cfg_q.jump_limit     <= amff_pkg::RST_JUMP_LIMIT;
      cfg_q.alpha_set      <= amff_pkg::RST_ALPHA_SET;
      cfg_q.gain_set       <= amff_pkg::RST_GAIN_SET;
    end else if (wr_en) begin
      unique case (idx)
        amff_pkg::REG_DEAD_BAND:   cfg_q.dead_band      <= pwdata[30:0];
        amff_pkg::REG_STEP_THR:    cfg_q.step_threshold <= pwdata[30:0];
        amff_pkg::REG_RAMP_THR:    cfg_q.ramp_threshold <= pwdata[30:0];
        amff_pkg::REG_CORNER_HOLD: cfg_q.corner_hold_ms <= pwdata[15:0];
        amff_pkg::REG_JUMP_LIMIT:  cfg_q.jump_limit     <= pwdata[30:0];
        amff_pkg::REG_ALPHA_SET:   cfg_q.alpha_set      <= pwdata;
        amff_pkg::REG_GAIN_SET:    cfg_q.gain_set       <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      amff_pkg::REG_DEAD_BAND:   prdata = 64'(cfg_q.dead_band);
      amff_pkg::REG_STEP_THR:    prdata = 64'(cfg_q.step_threshold);
      amff_pkg::REG_RAMP_THR:    prdata = 64'(cfg_q.ramp_threshold);
      amff_pkg::REG_CORNER_HOLD: prdata = 64'(cfg_q.corner_hold_ms);
      amff_pkg::REG_JUMP_LIMIT:  prdata = 64'(cfg_q.jump_limit);
      amff_pkg::REG_ALPHA_SET:   prdata = cfg_q.alpha_set;
      amff_pkg::REG_GAIN_SET:    prdata = 64'(cfg_q.gain_set);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/amff_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// no package dependencies
`default_nettype none

module amff_div #(
  parameter int unsigned NUM_W = 42,
  parameter int unsigned DEN_W = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign done_o  = done_q;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/adaptive_mode_follower_filter_core.sv -----
// adaptive mode follower filter, top level: sequencer, shared multiplier, state
// depends on amff_pkg, amff_regs, amff_div and the assertion macro header
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o  in_data_i (amff_pkg::in_t)
//   out       output     out_valid_o/out_ready_i out_data_o (amff_pkg::out_t)
//   config    apb        psel/penable/pready    paddr, pwdata, prdata
//
// one transaction at a time; in_ready_o is high only while the sequencer is idle
// rejected and first samples go S_EVAL to S_OUT; the rest end in S_FF, S_AMUL, S_SM, S_OUT
// step and corner with dt of 2 or more go through S_FFMUL and S_ACC before S_FF
// ramp, dt of 2 or more: S_MULK, S_DINIT, S_DIV (42-bit divide), S_NEG, S_MLO, S_MHI, S_ACC
// a finished result sits in the output register while the next transaction is taken
// reset clears all follower state and loads the register defaults
`default_nettype none

module adaptive_mode_follower_filter_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire amff_pkg::in_t                in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output amff_pkg::out_t                    out_data_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [amff_pkg::PADDR_W-1:0] paddr,
  input  wire logic [amff_pkg::PDATA_W-1:0] pwdata,
  output logic      [amff_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);

`include "adaptive_mode_follower_filter_core_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_EVAL, S_MULK, S_DINIT, S_DIV, S_NEG, S_MLO,
    S_MHI, S_FFMUL, S_ACC, S_FF, S_AMUL, S_SM, S_OUT
  } state_e;

  amff_pkg::cfg_t cfg;

  state_e                state_q;
  logic signed [31:0]    raw_q, smoothed_q, prev_cmd_q, prev_ff_q, last_raw_q, ff_q;
  logic        [31:0]    t_q, prev_time_q, rev_time_q;
  logic                  started_q, rev_flag_q, pd_pos_q, pd_neg_q, rej_q, accd_q, neg_q;
  amff_pkg::mode_e       mode_q;
  logic signed [32:0]    delta_q, gapd_q;
  logic        [32:0]    gap_q;
  logic        [9:0]     dt_q;
  logic        [15:0]    alpha_q, gain_q;
  logic signed [50:0]    prod_q;
  logic signed [60:0]    acc_q;
  logic signed [42:0]    vel_q;
  logic                  out_valid_q;
  amff_pkg::out_t        out_q;

  logic signed [32:0]    jump_d, delta_eff;
  logic        [32:0]    jump_mag, gap, delta_mag;
  logic        [31:0]    tdiff, thold;
  logic                  reject, in_band, rev_set, expire, flag_new;
  logic signed [33:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic signed [50:0]    mul_p, prod_mag;
  logic signed [60:0]    ff_w;
  logic signed [50:0]    sm_r;
  logic signed [51:0]    sm_sum;
  logic                  div_start, div_done;
  logic        [41:0]    div_quo;

  amff_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign div_start = (state_q == S_DINIT);
  assign prod_mag  = prod_q[50] ? -prod_q : prod_q;

  amff_div #(
    .NUM_W (42),
    .DEN_W (10)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_mag[41:0]),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign pready      = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign jump_d   = 33'(raw_q) - 33'(last_raw_q);
  assign jump_mag = jump_d[32] ? 33'(-jump_d) : 33'(jump_d);
  assign reject   = started_q && (jump_mag > {2'b0, cfg.jump_limit});
  assign tdiff    = t_q - prev_time_q;

  assign gap       = gapd_q[32] ? 33'(-gapd_q) : 33'(gapd_q);
  assign in_band   = gap < {2'b0, cfg.dead_band};
  assign delta_eff = in_band ? '0 : delta_q;
  assign delta_mag = delta_eff[32] ? 33'(-delta_eff) : 33'(delta_eff);
  assign rev_set   = !in_band && ((delta_eff[32] && pd_pos_q) ||
                                  (!delta_eff[32] && (delta_eff != '0) && pd_neg_q));
  assign thold     = t_q - rev_time_q;
  assign expire    = thold > {16'b0, cfg.corner_hold_ms};
  assign flag_new  = rev_set || (rev_flag_q && !expire);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MULK: begin
        mul_a = 34'(delta_q);
        mul_b = $signed(amff_pkg::MS_PER_S);
      end
      S_FFMUL: begin
        mul_a = (mode_q == amff_pkg::MODE_STEP) ? $signed({1'b0, gap_q}) : 34'(prev_ff_q);
        mul_b = $signed({1'b0, gain_q});
      end
      S_MLO: begin
        mul_a = $signed({13'b0, vel_q[20:0]});
        mul_b = $signed({1'b0, gain_q});
      end
      S_MHI: begin
        mul_a = 34'($signed(vel_q[42:21]));
        mul_b = $signed({1'b0, gain_q});
      end
      S_AMUL: begin
        mul_a = 34'(gapd_q);
        mul_b = $signed({1'b0, alpha_q});
      end
      default: ;
    endcase
  end

  assign mul_p  = 51'(mul_a) * 51'(mul_b);
  assign ff_w   = (acc_q + 61'sd8192) >>> 14;
  assign sm_r   = (prod_q + 51'sd16384) >>> 15;
  assign sm_sum = 52'(smoothed_q) + 52'(sm_r);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      smoothed_q  <= '0;
      prev_cmd_q  <= '0;
      pd_pos_q    <= 1'b0;
      pd_neg_q    <= 1'b0;
      prev_ff_q   <= '0;
      prev_time_q <= '0;
      rev_flag_q  <= 1'b0;
      rev_time_q  <= '0;
      last_raw_q  <= '0;
      mode_q      <= amff_pkg::MODE_STILL;
      accd_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: state_q <= S_EVAL;
        S_EVAL: begin
          last_raw_q <= raw_q;
          if (rej_q) begin
            accd_q  <= 1'b0;
            state_q <= S_OUT;
          end else if (!started_q) begin
            smoothed_q  <= raw_q;
            prev_cmd_q  <= raw_q;
            pd_pos_q    <= 1'b0;
            pd_neg_q    <= 1'b0;
            prev_ff_q   <= '0;
            prev_time_q <= t_q;
            started_q   <= 1'b1;
            mode_q      <= amff_pkg::MODE_STILL;
            accd_q      <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            accd_q      <= 1'b1;
            prev_cmd_q  <= raw_q;
            prev_time_q <= t_q;
            pd_pos_q    <= !delta_eff[32] && (delta_eff != '0);
            pd_neg_q    <= delta_eff[32];
            rev_flag_q  <= flag_new;
            if (rev_set) begin
              rev_time_q <= t_q;
            end
            if (delta_mag > {2'b0, cfg.step_threshold}) begin
              mode_q  <= amff_pkg::MODE_STEP;
              state_q <= S_FFMUL;
            end else if (flag_new) begin
              mode_q  <= amff_pkg::MODE_CORNER;
              state_q <= (dt_q >= 10'd2) ? S_FFMUL : S_FF;
            end else if (gap > {2'b0, cfg.ramp_threshold}) begin
              mode_q  <= amff_pkg::MODE_RAMP;
              state_q <= (dt_q >= 10'd2) ? S_MULK : S_FF;
            end else begin
              mode_q  <= amff_pkg::MODE_STILL;
              state_q <= S_FF;
            end
          end
        end
        S_MULK:  state_q <= S_DINIT;
        S_DINIT: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_NEG;
          end
        end
        S_NEG:   state_q <= S_MLO;
        S_MLO:   state_q <= S_MHI;
        S_MHI:   state_q <= S_ACC;
        S_FFMUL: state_q <= S_ACC;
        S_ACC:   state_q <= S_FF;
        S_FF:    state_q <= S_AMUL;
        S_AMUL:  state_q <= S_SM;
        S_SM: begin
          smoothed_q <= amff_pkg::sat32(64'(sm_sum));
          prev_ff_q  <= ff_q;
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        raw_q <= in_data_i.raw_angle;
        t_q   <= in_data_i.time_ms;
      end
      S_PREP: begin
        rej_q   <= reject;
        delta_q <= 33'(raw_q) - 33'(prev_cmd_q);
        gapd_q  <= 33'(raw_q) - 33'(smoothed_q);
        if (t_q > prev_time_q) begin
          dt_q <= (tdiff > 32'(amff_pkg::DT_MAX_MS)) ? amff_pkg::DT_MAX_MS : tdiff[9:0];
        end else begin
          dt_q <= '0;
        end
      end
      S_EVAL: begin
        delta_q <= delta_eff;
        gap_q   <= gap;
        acc_q   <= '0;
        if (delta_mag > {2'b0, cfg.step_threshold}) begin
          alpha_q <= cfg.alpha_set[47:32];
          gain_q  <= cfg.gain_set[15:0];
        end else if (flag_new) begin
          alpha_q <= cfg.alpha_set[63:48];
          gain_q  <= cfg.gain_set[31:16];
        end else if (gap > {2'b0, cfg.ramp_threshold}) begin
          alpha_q <= cfg.alpha_set[31:16];
          gain_q  <= cfg.gain_set[47:32];
        end else begin
          alpha_q <= cfg.alpha_set[15:0];
          gain_q  <= cfg.gain_set[15:0];
        end
      end
      S_MULK:  prod_q <= mul_p;
      S_DINIT: neg_q  <= prod_q[50];
      S_NEG:   vel_q  <= neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      S_MLO:   prod_q <= mul_p;
      S_MHI: begin
        prod_q <= mul_p;
        acc_q  <= 61'(prod_q);
      end
      S_FFMUL: begin
        prod_q <= mul_p;
        acc_q  <= '0;
      end
      S_ACC: begin
        acc_q <= acc_q + ((mode_q == amff_pkg::MODE_RAMP) ? (61'(prod_q) <<< 21)
                                                           : 61'(prod_q));
      end
      S_FF:   ff_q   <= amff_pkg::sat32(64'(ff_w));
      S_AMUL: prod_q <= mul_p;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.filtered_angle <= smoothed_q;
          out_q.velocity_ff    <= prev_ff_q;
          out_q.follow_mode    <= mode_q;
          out_q.accepted       <= accd_q;
        end
      end
      default: ;
    endcase
  end

  `AMFF_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "ready after take")
  `AMFF_ASSERT_NOW(a_result_frees_seq, $rose(out_valid_o), in_ready_o, "result without idle")
  `AMFF_ASSERT_NEXT(a_div_to_neg, (state_q == S_DIV) && div_done, state_q == S_NEG, "div exit")
  `AMFF_ASSERT_NOW(a_reject_keeps, (state_q == S_EVAL) && rej_q, started_q, "reject unstarted")

endmodule

`default_nettype wire

// ----- tb/adaptive_mode_follower_filter_core_test.sv -----
// self-checking testbench for adaptive_mode_follower_filter_core: random stalls on both sides,
// apb register phases, predictor and result queue kept in a scoreboard class
// depends on amff_pkg and the core rtl
`timescale 1ns / 1ps

module adaptive_mode_follower_filter_core_test;
  import amff_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 80;

  class follower_scoreboard;
    out_t        pending[$];
    int unsigned errors;
    logic [30:0] dead_band, step_thr, ramp_thr, jump_limit;
    logic [15:0] corner_hold;
    logic [63:0] alphas;
    logic [47:0] gains;
    bit          started, reversed;
    longint      smooth, prev_cmd, prev_delta, prev_ff, last_raw;
    int unsigned prev_t, rev_t;
    mode_e       mode;

    function new();
      dead_band   = RST_DEAD_BAND;
      step_thr    = RST_STEP_THR;
      ramp_thr    = RST_RAMP_THR;
      corner_hold = RST_CORNER_HOLD;
      jump_limit  = RST_JUMP_LIMIT;
      alphas      = RST_ALPHA_SET;
      gains       = RST_GAIN_SET;
      started = 0; reversed = 0;
      smooth = 0; prev_cmd = 0; prev_delta = 0; prev_ff = 0; last_raw = 0;
      prev_t = 0; rev_t = 0;
      mode = MODE_STILL;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_DEAD_BAND:   dead_band   = v[30:0];
        REG_STEP_THR:    step_thr    = v[30:0];
        REG_RAMP_THR:    ramp_thr    = v[30:0];
        REG_CORNER_HOLD: corner_hold = v[15:0];
        REG_JUMP_LIMIT:  jump_limit  = v[30:0];
        REG_ALPHA_SET:   alphas      = v;
        REG_GAIN_SET:    gains       = v[47:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // nearest, ties up
    function longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function void note_input(in_t x);
      longint raw, delta, gap, alpha, ff, vel;
      int unsigned t, dt;
      bit in_band;
      out_t e;
      raw = $signed(x.raw_angle);
      t = x.time_ms;
      e.accepted = 1'b1;
      if (started && mag(raw - last_raw) > longint'(jump_limit)) begin
        e.accepted = 1'b0;
      end else if (!started) begin
        smooth = raw; prev_cmd = raw; prev_delta = 0; prev_ff = 0;
        prev_t = t; started = 1; mode = MODE_STILL;
      end else begin
        delta = raw - prev_cmd;
        gap = mag(raw - smooth);
        in_band = gap < longint'(dead_band);
        dt = 0;
        ff = 0;
        if (t > prev_t) begin
          dt = t - prev_t;
          if (dt > 1000) dt = 1000;
        end
        if (in_band) delta = 0;
        if (!in_band && ((delta < 0 && prev_delta > 0) || (delta > 0 && prev_delta < 0))) begin
          reversed = 1;
          rev_t = t;
        end
        if (reversed && (t - rev_t) > corner_hold) reversed = 0;
        if (mag(delta) > longint'(step_thr)) begin
          alpha = alphas[47:32];
          ff = rnd_shift(gap * longint'(gains[15:0]), 14);
          mode = MODE_STEP;
        end else if (reversed) begin
          alpha = alphas[63:48];
          if (dt >= 2) ff = rnd_shift(prev_ff * longint'(gains[31:16]), 14);
          mode = MODE_CORNER;
        end else if (gap > longint'(ramp_thr)) begin
          alpha = alphas[31:16];
          if (dt >= 2) begin
            vel = (delta * 1000) / longint'(dt);
            ff = rnd_shift(vel * longint'(gains[47:32]), 14);
          end
          mode = MODE_RAMP;
        end else begin
          alpha = alphas[15:0];
          mode = MODE_STILL;
        end
        smooth = clamp32(smooth + rnd_shift((raw - smooth) * alpha, 15));
        prev_ff = clamp32(ff);
        prev_cmd = raw;
        prev_delta = clamp32(delta);
        prev_t = t;
      end
      last_raw = raw;
      e.filtered_angle = smooth[31:0];
      e.velocity_ff    = prev_ff[31:0];
      e.follow_mode    = mode;
      pending.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction", got.filtered_angle, 32'h0);
      end else begin
        e = pending.pop_front();
        if (got.filtered_angle !== e.filtered_angle)
          report("filtered_angle", got.filtered_angle, e.filtered_angle);
        if (got.velocity_ff !== e.velocity_ff)
          report("velocity_ff", got.velocity_ff, e.velocity_ff);
        if (got.follow_mode !== e.follow_mode)
          report("follow_mode", 32'(got.follow_mode), 32'(e.follow_mode));
        if (got.accepted !== e.accepted)
          report("accepted", 32'(got.accepted), 32'(e.accepted));
      end
    endtask
  endclass

  logic                clk_i, rst_ni;
  logic                in_valid, in_ready, out_valid, out_ready;
  in_t                 in_data;
  out_t                out_data;
  logic                psel, penable, pwrite, pready;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata, prdata;

  follower_scoreboard  sb;
  int unsigned         idle_cycles, results_seen;
  longint              walk;
  int unsigned         clock_ms;

  adaptive_mode_follower_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [63:0] v);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 3; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_item(logic [31:0] raw, logic [31:0] t);
    int unsigned g;
    g = pick_gap();
    if (g > 0 && in_valid) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      g--;
    end
    repeat (g) @(negedge clk_i);
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data.raw_angle <= raw;
    in_data.time_ms <= t;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(in_data);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(int kind);
    logic [63:0] v[7];
    case (kind)
      0: begin
        v = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
      end
      1: begin
        v = '{64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff, 64'hffff, 64'h7fff_ffff,
              64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff};
      end
      2: begin
        v = '{64'd32768, 64'd393216, 64'd52429, 64'd200, 64'd524288,
              64'd5072868695049768141, 64'd63333909856256};
      end
      default: begin
        v[0] = $urandom_range(0, 1 << 17);
        v[1] = $urandom_range(1 << 15, 1 << 19);
        v[2] = $urandom_range(0, 1 << 17);
        v[3] = $urandom_range(0, 600);
        v[4] = $urandom_range(1 << 17, 1 << 21);
        v[5] = {$urandom, $urandom};
        v[6] = {16'($urandom), $urandom};
      end
    endcase
    for (int i = 0; i < 7; i++) apb_write(3'(i), v[i]);
  endtask

  task automatic random_items(int n);
    int unsigned r, span;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item($urandom, $urandom);
      end else begin
        span = 1 << $urandom_range(6, 20);
        walk = walk + longint'($urandom_range(0, 2 * span)) - span;
        r = $urandom_range(0, 99);
        if (r < 8) clock_ms = clock_ms - $urandom_range(0, 5);
        else if (r < 14) clock_ms = clock_ms + $urandom_range(900, 5000);
        else clock_ms = clock_ms + $urandom_range(0, 40);
        send_item(walk[31:0], clock_ms);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    walk = 0;
    clock_ms = 32'hffff_ff00;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, default registers
    send_item(32'd100000, 32'd1000);
    send_item(32'd700000, 32'd1010);
    send_item(32'd110000, 32'd1010);
    send_item(32'd130000, 32'd1011);
    send_item(32'd200000, 32'd1013);
    send_item(32'd500000, 32'd1020);
    send_item(32'd480000, 32'd1030);
    send_item(32'd470000, 32'd1029);
    send_item(32'd520000, 32'd9000);
    send_item(32'd600000, 32'd9005);
    send_item(32'd600100, 32'd9500);
    send_item(32'd600100, 32'd9500);
    wait_drained();

    load_config(1);
    send_item(32'h7fff_ffff, 32'h0000_0000);
    send_item(32'h8000_0000, 32'hffff_ffff);
    send_item(32'h8000_0000, 32'h0000_0002);
    send_item(32'h7fff_ffff, 32'h0000_0005);
    send_item(32'h0000_0000, 32'hffff_ffff);
    send_item(32'h8000_0000, 32'h0000_0010);
    random_items(200);
    wait_drained();

    load_config(0);
    random_items(150);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      load_config(3);
      random_items(250);
      wait_drained();
    end

    load_config(2);
    random_items(150);
    wait_drained();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (results_seen == 60) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        results_seen++;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.check_result(out_data);
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
